/* rtl/assert_macros.svh */
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication check, disabled while reset is low.
`define ASSERT_IMPL(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also runs during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/bdc_pkg.sv */
// ----------------------------------------------------------------------------
// bdc_pkg
// Shared constants for the b-dot detumble coil drive pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package bdc_pkg;
  localparam int DEF_SAMPLE_WIDTH = 16;
  localparam int DEF_COEF_WIDTH   = 16;
  localparam int GAIN_W           = 32;
  localparam int FLOOR_W          = 32;
  localparam int GAIN_FRAC        = 16;
  localparam int COIL_FRAC        = 11;
  localparam int MOMENT_W         = 32;
  localparam int REG_IDX_W        = 3;

  localparam logic [REG_IDX_W-1:0] REG_GAIN   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_FLOOR  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_ROW_X  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_ROW_Y  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_ROW_Z  = 3'd4;
endpackage
`default_nettype wire

/* rtl/bdc_if.sv */
// ----------------------------------------------------------------------------
// bdc_sample_if / bdc_coil_if
// Valid/ready channels for the sample input and the coil current output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface bdc_sample_if #(parameter int W = 16);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] rate_x;
  logic signed [W-1:0] rate_y;
  logic signed [W-1:0] rate_z;
  logic signed [W-1:0] field_x;
  logic signed [W-1:0] field_y;
  logic signed [W-1:0] field_z;
  modport source (output valid, rate_x, rate_y, rate_z, field_x, field_y, field_z,
                  input ready);
  modport sink (input valid, rate_x, rate_y, rate_z, field_x, field_y, field_z,
                output ready);
endinterface

interface bdc_coil_if #(parameter int W = 16);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] current_x;
  logic signed [W-1:0] current_y;
  logic signed [W-1:0] current_z;
  logic                clipped;
  modport source (output valid, current_x, current_y, current_z, clipped,
                  input ready);
  modport sink (input valid, current_x, current_y, current_z, clipped,
                output ready);
endinterface
`default_nettype wire

/* rtl/bdc_front.sv */
// ----------------------------------------------------------------------------
// bdc_front
// Three stages: capture sample, form products, form floored |B|^2 and rate x B.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module bdc_front #(
  parameter int SW = 16,
  parameter int DW = 32
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       en_i,
  input  wire logic                       valid_i,
  input  wire logic signed [3*SW-1:0]     rate_i,
  input  wire logic signed [3*SW-1:0]     field_i,
  input  wire logic [bdc_pkg::FLOOR_W-1:0] floor_i,
  output logic                            valid_o,
  output logic [DW-1:0]                   div_o,
  output logic [3*(2*SW+1)-1:0]           cross_o
);
  import bdc_pkg::*;
  localparam int PW = 2 * SW;
  localparam int CX = PW + 1;

  logic                 v1_q, v2_q, v3_q;
  logic signed [SW-1:0] r_q [3];
  logic signed [SW-1:0] f_q [3];
  logic signed [PW-1:0] sq_q [3];
  logic signed [PW-1:0] pa_q [3];
  logic signed [PW-1:0] pb_q [3];
  logic [DW-1:0]        div_d, div_q, sum_w, floor_w;
  logic [3*CX-1:0]      cross_d, cross_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        r_q[k]  <= rate_i[k*SW +: SW];
        f_q[k]  <= field_i[k*SW +: SW];
        sq_q[k] <= f_q[k] * f_q[k];
      end
      pa_q[0] <= r_q[1] * f_q[2];
      pb_q[0] <= r_q[2] * f_q[1];
      pa_q[1] <= r_q[2] * f_q[0];
      pb_q[1] <= r_q[0] * f_q[2];
      pa_q[2] <= r_q[0] * f_q[1];
      pb_q[2] <= r_q[1] * f_q[0];
      div_q   <= div_d;
      cross_q <= cross_d;
    end
  end

  always_comb begin
    // Squares are non-negative, so zero extension is exact.
    sum_w = DW'($unsigned(sq_q[0])) + DW'($unsigned(sq_q[1]))
          + DW'($unsigned(sq_q[2]));
    floor_w = DW'(floor_i);
    div_d = (sum_w > floor_w) ? sum_w : floor_w;
    if (div_d == '0) begin
      div_d = DW'(1);
    end
    for (int k = 0; k < 3; k++) begin
      cross_d[k*CX +: CX] = CX'(pa_q[k]) - CX'(pb_q[k]);
    end
  end

  assign valid_o = v3_q;
  assign div_o   = div_q;
  assign cross_o = cross_q;
endmodule
`default_nettype wire

/* rtl/bdc_div.sv */
// ----------------------------------------------------------------------------
// bdc_div
// Pipelined restoring divider, one quotient bit per stage; carries rate x B.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module bdc_div #(
  parameter int DW = 32,
  parameter int XW = 99
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       en_i,
  input  wire logic                       valid_i,
  input  wire logic [bdc_pkg::GAIN_W-1:0] num_i,
  input  wire logic [DW-1:0]              den_i,
  input  wire logic [XW-1:0]              side_i,
  output logic                            valid_o,
  output logic [bdc_pkg::GAIN_W-1:0]      quo_o,
  output logic [XW-1:0]                   side_o
);
  import bdc_pkg::*;
  localparam int NS = GAIN_W;

  logic              v_q    [NS];
  logic [DW-1:0]     rem_q  [NS];
  logic [NS-1:0]     num_q  [NS];
  logic [DW-1:0]     den_q  [NS];
  logic [XW-1:0]     side_q [NS];

  for (genvar i = 0; i < NS; i++) begin : g_stage
    logic          v_w;
    logic [DW-1:0] rem_w, den_w;
    logic [NS-1:0] num_w;
    logic [XW-1:0] side_w;
    logic [DW:0]   trial_w;
    logic          ge_w;

    if (i == 0) begin : g_first
      assign v_w    = valid_i;
      assign rem_w  = '0;
      assign num_w  = num_i;
      assign den_w  = den_i;
      assign side_w = side_i;
    end else begin : g_next
      assign v_w    = v_q[i-1];
      assign rem_w  = rem_q[i-1];
      assign num_w  = num_q[i-1];
      assign den_w  = den_q[i-1];
      assign side_w = side_q[i-1];
    end

    assign trial_w = {rem_w, num_w[NS-1]};
    assign ge_w    = (trial_w >= {1'b0, den_w});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (en_i) begin
        v_q[i] <= v_w;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        // Remainder stays below the divisor, so the top bit drops out.
        rem_q[i]  <= ge_w ? DW'(trial_w - {1'b0, den_w}) : DW'(trial_w);
        num_q[i]  <= {num_w[NS-2:0], ge_w};
        den_q[i]  <= den_w;
        side_q[i] <= side_w;
      end
    end
  end

  assign valid_o = v_q[NS-1];
  assign quo_o   = num_q[NS-1];
  assign side_o  = side_q[NS-1];
endmodule
`default_nettype wire

/* rtl/bdc_back.sv */
// ----------------------------------------------------------------------------
// bdc_back
// Moment scaling, coil matrix product and output saturation; four stages,
// the last one is the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module bdc_back #(
  parameter int SW = 16,
  parameter int CW = 16
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       en_i,
  input  wire logic                       valid_i,
  input  wire logic [bdc_pkg::GAIN_W-1:0] gain_i,
  input  wire logic [3*(2*SW+1)-1:0]      cross_i,
  input  wire logic [3*CW-1:0]            row_i [3],
  output logic                            valid_o,
  output logic signed [SW-1:0]            cur_o [3],
  output logic                            clip_o
);
  import bdc_pkg::*;
  localparam int CX  = 2 * SW + 1;
  localparam int PW  = GAIN_W + CX;
  localparam int UW  = PW + 1 - GAIN_FRAC;
  localparam int TW  = MOMENT_W + CW;
  localparam int AW  = TW + 2;
  localparam logic [UW-1:0] MAX_POS = UW'((64'd1 << (MOMENT_W - 1)) - 64'd1);
  localparam logic [UW-1:0] MAX_NEG = UW'(64'd1 << (MOMENT_W - 1));
  localparam logic signed [MOMENT_W-1:0] M_HI = {1'b0, {(MOMENT_W-1){1'b1}}};
  localparam logic signed [MOMENT_W-1:0] M_LO = {1'b1, {(MOMENT_W-1){1'b0}}};
  localparam logic signed [AW-1:0] O_HI = AW'({1'b0, {(SW-1){1'b1}}});
  localparam logic signed [AW-1:0] O_LO = -O_HI - AW'(1);

  logic                       v1_q, v2_q, v3_q, v4_q;
  logic                       neg_q [3];
  logic [PW-1:0]              p_q [3];
  logic signed [MOMENT_W-1:0] m_d [3];
  logic signed [MOMENT_W-1:0] m_q [3];
  logic                       clip2_d, clip2_q, clip3_q, clip4_d, clip4_q;
  logic signed [TW-1:0]       t_q [3][3];
  logic signed [SW-1:0]       cur_d [3];
  logic signed [SW-1:0]       cur_q [3];
  logic signed [CX-1:0]       c_w [3];
  logic [CX-1:0]              mag_w [3];
  logic [UW-1:0]              u_w [3];
  logic signed [AW-1:0]       acc_w [3];
  logic signed [AW-1:0]       sh_w [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      c_w[k]   = cross_i[k*CX +: CX];
      mag_w[k] = c_w[k][CX-1] ? CX'(-c_w[k]) : CX'(c_w[k]);
    end
  end

  // Moment: floor(gain * c / 2^16), saturated to 32 bits.
  always_comb begin
    clip2_d = 1'b0;
    for (int k = 0; k < 3; k++) begin
      if (neg_q[k]) begin
        u_w[k] = UW'(({1'b0, p_q[k]} + (PW+1)'((1 << GAIN_FRAC) - 1)) >> GAIN_FRAC);
        if (u_w[k] > MAX_NEG) begin
          m_d[k]  = M_LO;
          clip2_d = 1'b1;
        end else begin
          m_d[k] = MOMENT_W'(-u_w[k]);
        end
      end else begin
        u_w[k] = UW'(p_q[k] >> GAIN_FRAC);
        if (u_w[k] > MAX_POS) begin
          m_d[k]  = M_HI;
          clip2_d = 1'b1;
        end else begin
          m_d[k] = MOMENT_W'(u_w[k]);
        end
      end
    end
  end

  // Current: floor(sum / 2^11), saturated to the sample width.
  always_comb begin
    clip4_d = clip3_q;
    for (int i = 0; i < 3; i++) begin
      acc_w[i] = AW'(t_q[i][0]) + AW'(t_q[i][1]) + AW'(t_q[i][2]);
      sh_w[i]  = acc_w[i] >>> COIL_FRAC;
      if (sh_w[i] > O_HI) begin
        cur_d[i] = SW'(O_HI);
        clip4_d  = 1'b1;
      end else if (sh_w[i] < O_LO) begin
        cur_d[i] = SW'(O_LO);
        clip4_d  = 1'b1;
      end else begin
        cur_d[i] = SW'(sh_w[i]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        neg_q[k] <= c_w[k][CX-1];
        p_q[k]   <= PW'(gain_i) * PW'(mag_w[k]);
        m_q[k]   <= m_d[k];
      end
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          t_q[i][k] <= TW'(m_q[k]) * TW'($signed(row_i[i][k*CW +: CW]));
        end
        cur_q[i] <= cur_d[i];
      end
      clip2_q <= clip2_d;
      clip3_q <= clip2_q;
      clip4_q <= clip4_d;
    end
  end

  assign valid_o = v4_q;
  assign cur_o   = cur_q;
  assign clip_o  = clip4_q;
endmodule
`default_nettype wire

/* rtl/bdot_detumble_coil_drive_unit.sv */
// ----------------------------------------------------------------------------
// bdot_detumble_coil_drive_unit
// B-dot detumble law: magnetic moment from rate x field over |B|^2, mapped
// through a 3x3 coil matrix to three saturated coil currents.
// ----------------------------------------------------------------------------
// Usage:
//   sample_i carries one sample (rate and field, three axes); coil_o carries
//   one result (three currents and a clipped flag) per sample, in order.
//   Registers are written through cfg_we_i / cfg_idx_i / cfg_data_i. The user
//   must write them only while the pipeline is empty; the block itself does
//   not enforce this. Unknown indexes are ignored.
//   Stages: 3 front, 32 divider (one quotient bit each) and 4 back, the last
//   of which is the output register; the divider sets the depth.
//   Throughput: one sample per cycle; every stage takes a new item each cycle,
//   as long as the pipeline is not stalled.
//   Stall: the whole pipeline holds while a result sits in the output
//   register and the receiver is not ready; sample_i.ready follows that.
//   Bubbles move forward while the output register is empty.
//   Reset: all valid bits clear, gain reads 0, the |B|^2 floor reads 1 and
//   the coil matrix reads 0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module bdot_detumble_coil_drive_unit #(
  parameter int SAMPLE_WIDTH = bdc_pkg::DEF_SAMPLE_WIDTH,
  parameter int COEF_WIDTH   = bdc_pkg::DEF_COEF_WIDTH
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [bdc_pkg::REG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [((3*COEF_WIDTH > bdc_pkg::GAIN_W) ? 3*COEF_WIDTH
                      : bdc_pkg::GAIN_W)-1:0] cfg_data_i,
  bdc_sample_if.sink                        sample_i,
  bdc_coil_if.source                        coil_o
);
  import bdc_pkg::*;
  localparam int SW = SAMPLE_WIDTH;
  localparam int CW = COEF_WIDTH;
  localparam int RW = 3 * CW;
  localparam int DW = (2 * SW > FLOOR_W) ? 2 * SW : FLOOR_W;
  localparam int XW = 3 * (2 * SW + 1);

  // Configuration registers.
  logic [GAIN_W-1:0]  gain_q;
  logic [FLOOR_W-1:0] floor_q;
  logic [RW-1:0]      row_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q  <= '0;
      floor_q <= FLOOR_W'(1);
      row_q   <= '{default: '0};
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_GAIN:  gain_q   <= GAIN_W'(cfg_data_i);
        REG_FLOOR: floor_q  <= FLOOR_W'(cfg_data_i);
        REG_ROW_X: row_q[0] <= RW'(cfg_data_i);
        REG_ROW_Y: row_q[1] <= RW'(cfg_data_i);
        REG_ROW_Z: row_q[2] <= RW'(cfg_data_i);
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  // Advance every stage unless a finished result waits on a stalled receiver.
  logic en;
  assign en = !coil_o.valid || coil_o.ready;
  assign sample_i.ready = en;

  logic              fr_valid, dv_valid;
  logic [DW-1:0]     fr_div;
  logic [XW-1:0]     fr_cross, dv_cross;
  logic [GAIN_W-1:0] dv_gain;
  logic signed [SW-1:0] cur [3];

  bdc_front #(.SW(SW), .DW(DW)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sample_i.valid),
    .rate_i  ({sample_i.rate_z, sample_i.rate_y, sample_i.rate_x}),
    .field_i ({sample_i.field_z, sample_i.field_y, sample_i.field_x}),
    .floor_i (floor_q),
    .valid_o (fr_valid),
    .div_o   (fr_div),
    .cross_o (fr_cross)
  );

  // Gain = gain_constant / floored |B|^2; rate x B rides alongside.
  bdc_div #(.DW(DW), .XW(XW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_valid),
    .num_i   (gain_q),
    .den_i   (fr_div),
    .side_i  (fr_cross),
    .valid_o (dv_valid),
    .quo_o   (dv_gain),
    .side_o  (dv_cross)
  );

  bdc_back #(.SW(SW), .CW(CW)) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (dv_valid),
    .gain_i  (dv_gain),
    .cross_i (dv_cross),
    .row_i   (row_q),
    .valid_o (coil_o.valid),
    .cur_o   (cur),
    .clip_o  (coil_o.clipped)
  );

  assign coil_o.current_x = cur[0];
  assign coil_o.current_y = cur[1];
  assign coil_o.current_z = cur[2];
endmodule
`default_nettype wire

/* rtl/bdc_checker.sv */
// ----------------------------------------------------------------------------
// bdc_checker
// Port-level checks on the coil drive unit, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module bdc_checker #(
  parameter int SW = 16
) (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          in_ready,
  input wire logic          out_valid,
  input wire logic          out_ready,
  input wire logic [SW-1:0] out_x
);
  `ASSERT_ALWAYS(a_rst_quiet, clk_i, !rst_ni |=> !out_valid || rst_ni, "result valid during reset")
  `ASSERT_IMPL(a_ready_rule, clk_i, rst_ni, in_ready == (!out_valid || out_ready), "input ready does not follow output stall")
  `ASSERT_IMPL(a_hold, clk_i, rst_ni, out_valid && !out_ready |=> out_valid && $stable(out_x), "stalled result changed")
  `ASSERT_IMPL(a_no_early, clk_i, rst_ni, $rose(rst_ni) |-> !out_valid, "result right after reset")
endmodule

bind bdot_detumble_coil_drive_unit bdc_checker #(.SW(SAMPLE_WIDTH)) u_bdc_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_ready  (sample_i.ready),
  .out_valid (coil_o.valid),
  .out_ready (coil_o.ready),
  .out_x     (coil_o.current_x)
);
`default_nettype wire
